### design/gws_pkg.sv
// package: sizes, result and control types, register codes and word helper for the matcher
`timescale 1ns / 1ps
`default_nettype none
package gws_pkg;

	localparam int WORD_MAX_DEF    = 10;
	localparam int MAX_ROWS_DEF    = 128;
	localparam int MAX_COLS_DEF    = 256;
	localparam int WORD_REGS_CHARS = 10;

	localparam int CH_W       = 8;
	localparam int LEN_W      = 4;
	localparam int OUT_ROW_W  = 8;
	localparam int OUT_COL_W  = 9;
	localparam int WORD_LO_W  = 64;
	localparam int WORD_HI_W  = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 64;
	localparam int RES_DEPTH  = 8;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_WORD_LO  = 2'd0,
		REG_WORD_HI  = 2'd1,
		REG_WORD_LEN = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [OUT_ROW_W-1:0] start_row;
		logic [OUT_COL_W-1:0] start_col;
		logic                 vertical;
		logic                 last;
	} res_t;

	typedef struct packed {
		logic step;
		logic clr;
	} cell_ctl_t;

	function automatic logic [CH_W-1:0] word_char(
		input logic [WORD_LO_W-1:0] lo,
		input logic [WORD_HI_W-1:0] hi,
		input int                   i
	);
		logic [CH_W-1:0] c;
		c = '0;
		if (i < 8) begin
			c = lo[CH_W*i +: CH_W];
		end else if (i < WORD_REGS_CHARS) begin
			c = hi[CH_W*(i-8) +: CH_W];
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### design/gws_char_if.sv
// interface: grid character channel
`timescale 1ns / 1ps
`default_nettype none
interface gws_char_if;
	logic                     valid;
	logic                     ready;
	logic [gws_pkg::CH_W-1:0] ch;
	logic                     last_in_row;
	logic                     last_in_grid;

	modport source (output valid, ch, last_in_row, last_in_grid, input ready);
	modport sink (input valid, ch, last_in_row, last_in_grid, output ready);
endinterface
`default_nettype wire

### design/gws_match_if.sv
// interface: match result channel
`timescale 1ns / 1ps
`default_nettype none
interface gws_match_if;
	logic                          valid;
	logic                          ready;
	logic [gws_pkg::OUT_ROW_W-1:0] start_row;
	logic [gws_pkg::OUT_COL_W-1:0] start_col;
	logic                          vertical;
	logic                          last;

	modport source (output valid, start_row, start_col, vertical, last, input ready);
	modport sink (input valid, start_row, start_col, vertical, last, output ready);
endinterface
`default_nettype wire

### design/gws_cfg_if.sv
// interface: configuration write channel
`timescale 1ns / 1ps
`default_nettype none
interface gws_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [gws_pkg::CFG_ADDR_W-1:0] addr;
	logic [gws_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

### design/grid_word_search_matcher.sv
// top level: word search over a raster text grid, horizontal and vertical matches
//
//   channel   dir  beat fields                              accepted when
//   chars     in   ch, last_in_row, last_in_grid            valid && ready
//   found     out  start_row, start_col, vertical, last     valid && ready
//   cfg       in   addr, data                               valid && ready (ready always high)
//
// one character per cycle unless stalled; results pass the match stage, then the queue
// column progress is in a ram read at accept, with a bypass of the last write
// a fill mark of reached columns stands for the clear at end of grid; no clearing pass
// chars stalls only while the result queue may lack room for two more results
// reset clears counters, row progress, fill mark, queue and word; sets word length to 1
`timescale 1ns / 1ps
`default_nettype none
module grid_word_search_matcher #(
	parameter int WORD_MAX = gws_pkg::WORD_MAX_DEF,
	parameter int MAX_ROWS = gws_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gws_pkg::MAX_COLS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	gws_char_if.sink   chars,
	gws_match_if.source found,
	gws_cfg_if.sink    cfg
);
	import gws_pkg::*;

	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int CW  = $clog2(MAX_COLS + 1);
	localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int MW  = (RW > CW) ? RW : CW;
	localparam int EW  = ((MW > OUT_COL_W) ? MW : OUT_COL_W) + 1;
	localparam int QCW = $clog2(RES_DEPTH + 1);

	// configuration
	logic [WORD_LO_W-1:0] word_lo_q;
	logic [WORD_HI_W-1:0] word_hi_q;
	logic [LEN_W-1:0]     word_len_q;
	logic                 len_ok;

	// accept stage
	logic          acc;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [CW-1:0] hwm_q;
	logic          inb_a;
	logic          colvld_a;

	// match stage
	logic            vld_s1;
	logic [CH_W-1:0] ch_s1;
	logic [RW-1:0]   row_s1;
	logic [CW-1:0]   col_s1;
	logic            inb_s1;
	logic            colvld_s1;
	logic            eor_s1;
	logic            eog_s1;
	logic            act;
	logic [AW-1:0]   addr_s1;

	// column ram and bypass
	logic [WORD_MAX-1:0] rd_data;
	logic [WORD_MAX-1:0] col_old;
	logic [WORD_MAX-1:0] col_new;
	logic                wr_vld_q;
	logic [AW-1:0]       wr_addr_q;
	logic [WORD_MAX-1:0] wr_data_q;
	logic                byp;

	// cell chain
	cell_ctl_t           ctl;
	logic [WORD_MAX-1:0] row_bits;
	logic [WORD_MAX-1:0] row_prev;
	logic [WORD_MAX-1:0] col_prev;
	logic [WORD_MAX-1:0] h_hits;
	logic [WORD_MAX-1:0] v_hits;
	logic                hit_h;
	logic                hit_v;

	// results
	logic [EW-1:0]  row_e;
	logic [EW-1:0]  col_e;
	logic [EW-1:0]  len_e;
	res_t           res_h;
	res_t           res_v;
	res_t           res0;
	res_t           res1;
	logic [1:0]     n_push;
	logic [QCW-1:0] res_cnt;
	res_t           head;
	logic           pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_lo_q  <= '0;
			word_hi_q  <= '0;
			word_len_q <= LEN_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.addr))
				REG_WORD_LO:  word_lo_q  <= cfg.data;
				REG_WORD_HI:  word_hi_q  <= cfg.data[WORD_HI_W-1:0];
				REG_WORD_LEN: word_len_q <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign len_ok = (word_len_q != '0) && (int'(word_len_q) <= WORD_MAX)
		&& (int'(word_len_q) <= WORD_REGS_CHARS);

	// accept stage: position counters and fill mark
	assign chars.ready = (int'(res_cnt) + (vld_s1 ? 2 : 0)) <= (RES_DEPTH - 2);
	assign acc         = chars.valid && chars.ready;
	assign inb_a       = (row_q < RW'(MAX_ROWS)) && (col_q < CW'(MAX_COLS));
	assign colvld_a    = col_q < hwm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			hwm_q <= '0;
		end else if (acc) begin
			if (chars.last_in_grid) begin
				row_q <= '0;
				col_q <= '0;
				hwm_q <= '0;
			end else begin
				if (inb_a && !colvld_a) begin
					hwm_q <= col_q + CW'(1);
				end
				if (chars.last_in_row) begin
					col_q <= '0;
					if (row_q < RW'(MAX_ROWS)) begin
						row_q <= row_q + RW'(1);
					end
				end else if (col_q < CW'(MAX_COLS)) begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ch_s1     <= chars.ch;
			row_s1    <= row_q;
			col_s1    <= col_q;
			inb_s1    <= inb_a;
			colvld_s1 <= colvld_a;
			eor_s1    <= chars.last_in_row;
			eog_s1    <= chars.last_in_grid;
		end
	end

	gws_ram #(
		.WIDTH (WORD_MAX),
		.DEPTH (MAX_COLS)
	) u_col_ram (
		.clk   (clk),
		.we    (act),
		.waddr (addr_s1),
		.wdata (col_new),
		.re    (acc),
		.raddr (col_q[AW-1:0]),
		.rdata (rd_data)
	);

	assign act     = vld_s1 && inb_s1;
	assign addr_s1 = col_s1[AW-1:0];
	assign byp     = wr_vld_q && (wr_addr_q == addr_s1);

	always_comb begin
		if (!colvld_s1) begin
			col_old = '0;
		end else if (byp) begin
			col_old = wr_data_q;
		end else begin
			col_old = rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else begin
			wr_vld_q <= act;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= addr_s1;
		wr_data_q <= col_new;
	end

	// shift-and cells, one per word position
	assign ctl.step = act;
	assign ctl.clr  = vld_s1 && (eor_s1 || eog_s1);

	for (genvar i = 0; i < WORD_MAX; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign row_prev[i] = 1'b1;
			assign col_prev[i] = 1'b1;
		end else begin : g_link
			assign row_prev[i] = row_bits[i-1];
			assign col_prev[i] = col_old[i-1];
		end

		gws_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.ch       (ch_s1),
			.word_ch  (word_char(word_lo_q, word_hi_q, i)),
			.en       (len_ok && (int'(word_len_q) > i)),
			.top      (len_ok && (int'(word_len_q) == i + 1)),
			.row_prev (row_prev[i]),
			.col_prev (col_prev[i]),
			.row_bit  (row_bits[i]),
			.col_bit  (col_new[i]),
			.h_hit    (h_hits[i]),
			.v_hit    (v_hits[i])
		);
	end

	assign hit_h = act && (|h_hits);
	assign hit_v = act && (|v_hits);

	// result coordinates
	assign row_e = EW'(row_s1);
	assign col_e = EW'(col_s1);
	assign len_e = EW'(word_len_q);

	always_comb begin
		res_h.start_row = OUT_ROW_W'(row_e + EW'(1));
		res_h.start_col = OUT_COL_W'(col_e + EW'(2) - len_e);
		res_h.vertical  = 1'b0;
		res_h.last      = !hit_v;
		res_v.start_row = OUT_ROW_W'(row_e + EW'(2) - len_e);
		res_v.start_col = OUT_COL_W'(col_e + EW'(1));
		res_v.vertical  = 1'b1;
		res_v.last      = 1'b1;
	end

	assign res0   = hit_h ? res_h : res_v;
	assign res1   = res_v;
	assign n_push = {1'b0, hit_h} + {1'b0, hit_v};

	gws_res_fifo #(
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (hit_h || hit_v),
		.res0   (res0),
		.push1  (hit_h && hit_v),
		.res1   (res1),
		.pop    (pop),
		.cnt    (res_cnt),
		.head   (head)
	);

	assign found.valid     = res_cnt != '0;
	assign found.start_row = head.start_row;
	assign found.start_col = head.start_col;
	assign found.vertical  = head.vertical;
	assign found.last      = head.last;
	assign pop             = found.valid && found.ready;

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (int'(res_cnt) + int'(n_push)) <= RES_DEPTH)
		else $error("result queue overflow");

	a_grid_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && chars.last_in_grid) |=> (row_q == '0 && col_q == '0 && hwm_q == '0))
		else $error("position not cleared at end of grid");

	a_row_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && (eor_s1 || eog_s1)) |=> (row_bits == '0))
		else $error("row progress not cleared at end of row");
`endif

endmodule
`default_nettype wire

### design/gws_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module gws_ram #(
	parameter int WIDTH = gws_pkg::WORD_MAX_DEF,
	parameter int DEPTH = gws_pkg::MAX_COLS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### design/gws_cell.sv
// one word position of the shift-and chain: compare, row prefix bit, column prefix bit
`timescale 1ns / 1ps
`default_nettype none
module gws_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gws_pkg::cell_ctl_t       ctl,
	input  logic [gws_pkg::CH_W-1:0] ch,
	input  logic [gws_pkg::CH_W-1:0] word_ch,
	input  logic                     en,
	input  logic                     top,
	input  logic                     row_prev,
	input  logic                     col_prev,
	output logic                     row_bit,
	output logic                     col_bit,
	output logic                     h_hit,
	output logic                     v_hit
);
	import gws_pkg::*;

	logic eq;
	logic h;
	logic row_q;

	assign eq      = en && (ch == word_ch);
	assign h       = row_prev && eq;
	assign col_bit = col_prev && eq;
	assign h_hit   = h && top;
	assign v_hit   = col_bit && top;
	assign row_bit = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 1'b0;
		end else if (ctl.clr) begin
			row_q <= 1'b0;
		end else if (ctl.step) begin
			row_q <= h;
		end
	end
endmodule
`default_nettype wire

### design/gws_res_fifo.sv
// result queue taking up to two results per cycle, one out per beat
`timescale 1ns / 1ps
`default_nettype none
module gws_res_fifo #(
	parameter int DEPTH = gws_pkg::RES_DEPTH,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push0,
	input  gws_pkg::res_t res0,
	input  logic          push1,
	input  gws_pkg::res_t res1,
	input  logic          pop,
	output logic [CW-1:0] cnt,
	output gws_pkg::res_t head
);
	import gws_pkg::*;

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    n_push;

	assign n_push = {1'b0, push0} + {1'b0, push1};
	assign cnt    = cnt_q;
	assign head   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wp_q] <= res0;
		end
		if (push1) begin
			mem_q[wp_q + PW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(n_push);
			rp_q  <= rp_q + PW'(pop);
			cnt_q <= cnt_q + CW'(n_push) - CW'(pop);
		end
	end
endmodule
`default_nettype wire
